@@ rtl/rmg_pkg.sv @@
// rmg_pkg: shared constants, types and width helpers for the generator top and its multiplier.
// No dependencies; imported by rmg_mul, reference_model_generator, rmg_model_monitor and the tb.
`timescale 1ns / 1ps

package rmg_pkg;

  // Defaults for the datapath parameters.
  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Port field width (register data, target and result fields).
  localparam int IO_W    = 32;
  // Slice of the second operand consumed by the multiplier each cycle.
  localparam int CHUNK_W = 16;

  // Configuration register indexes.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_LAG_BW   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_FILT_G1  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_FILT_G2  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ERR_GAIN = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ST_G1    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ST_G2    = 3'd5;

  // Top-level sequencer.
  typedef enum logic [1:0] {
    S_IDLE,
    S_ERR,
    S_MUL,
    S_POS
  } state_e;

  // Product schedule, in issue order. The drive must be final before OP_DBD.
  typedef enum logic [2:0] {
    OP_L1Q1,  // l1 * q1
    OP_L2Q2,  // l2 * q2
    OP_L0E,   // l0 * e   -> drive
    OP_ABD,   // a  * bd
    OP_DBD,   // d  * bd  -> a'
    OP_Q1G1,  // q1 * g1  -> q1'
    OP_Q1G2   // q1 * g2  -> q2'
  } op_e;

  // Width of the rounded, rescaled product for a given data width.
  function automatic int rnd_prod_w(input int dw, input int fb);
    return dw + ((dw + CHUNK_W - 1) / CHUNK_W) * CHUNK_W + 1 - fb;
  endfunction

endpackage

@@ rtl/rmg_mul.sv @@
// rmg_mul: sequential signed multiplier, one CHUNK_W slice of b per cycle, with
// round-to-nearest rescale by FRAC_BITS. Depends on rmg_pkg.
`timescale 1ns / 1ps

module rmg_mul import rmg_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              start_i,
  input  logic signed [DATA_WIDTH-1:0]                      a_i,
  input  logic signed [DATA_WIDTH-1:0]                      b_i,
  output logic                                              done_o,
  output logic signed [rnd_prod_w(DATA_WIDTH, FRAC_BITS)-1:0] res_o
);

  localparam int NCH = (DATA_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int BW  = NCH * CHUNK_W;
  localparam int PW  = DATA_WIDTH + BW + 1;
  localparam int PPW = DATA_WIDTH + CHUNK_W + 1;
  localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;
  localparam logic [CW-1:0] TOP = CW'(NCH - 1);
  localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic signed [DATA_WIDTH-1:0]   a_q;
  logic        [BW-1:0]           b_q;
  logic        [CW-1:0]           chunk_q;
  logic                           busy_q, first_q, done_q;
  logic signed [PW-1:0]           acc_q, acc_d;
  logic signed [PW-1:0]           acc_sh, pp_x, rnd;
  logic        [CHUNK_W-1:0]      slice;
  logic signed [CHUNK_W:0]        slice_x;
  logic signed [PPW-1:0]          pp;

  // Horner over slices, most significant (signed) slice first.
  always_comb begin
    slice   = b_q[chunk_q*CHUNK_W +: CHUNK_W];
    slice_x = (chunk_q == TOP) ? {slice[CHUNK_W-1], slice} : {1'b0, slice};
    pp      = PPW'(a_q) * PPW'(slice_x);
    pp_x    = PW'(pp);
    acc_sh  = first_q ? '0 : (acc_q <<< CHUNK_W);
    rnd     = (chunk_q == '0) ? HALF : '0;
    acc_d   = acc_sh + pp_x + rnd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      first_q <= 1'b0;
      done_q  <= 1'b0;
      chunk_q <= '0;
    end else begin
      done_q <= busy_q && (chunk_q == '0);
      if (start_i) begin
        busy_q  <= 1'b1;
        first_q <= 1'b1;
        chunk_q <= TOP;
      end else if (busy_q) begin
        first_q <= 1'b0;
        if (chunk_q == '0) begin
          busy_q <= 1'b0;
        end else begin
          chunk_q <= chunk_q - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= BW'(b_i);
    end
    if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = acc_q[PW-1:FRAC_BITS];

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("multiplier restarted while busy");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("multiplier done held longer than one cycle");

endmodule

@@ rtl/reference_model_generator.sv @@
// reference_model_generator: five-state fixed-point trajectory generator, one update per
// transaction. Depends on rmg_pkg and rmg_mul (shared multiplier).
`timescale 1ns / 1ps
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+---------------------------------------
//  in      | to block  | in_valid_i / in_stall_o  | target_i
//  out     | from blk  | out_valid_o / out_stall_i| drive_o, ref_position_o,
//          |           |                          |   ref_velocity_o, ref_acceleration_o
//  cfg     | to block  | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
//  A transaction runs seven products in turn on the single shared multiplier,
//  which takes one 16-bit slice of its second operand per cycle; each finished
//  product is folded into its running sum as the next one is issued.
//  Reset clears the configuration and the state registers to zero; no clearing pass.
//  in_stall_o is high from acceptance until the state update is committed.
//  A stalled result sits in the output register; the next transaction runs
//  meanwhile and waits only at commit if the previous result is still held.

module reference_model_generator import rmg_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [REG_IDX_W-1:0]   cfg_index_i,
  input  logic [IO_W-1:0]        cfg_wdata_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic signed [IO_W-1:0] target_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic signed [IO_W-1:0] drive_o,
  output logic signed [IO_W-1:0] ref_position_o,
  output logic signed [IO_W-1:0] ref_velocity_o,
  output logic signed [IO_W-1:0] ref_acceleration_o
);

  localparam int RW  = rnd_prod_w(DATA_WIDTH, FRAC_BITS);
  localparam int MW0 = (RW > DATA_WIDTH) ? RW : DATA_WIDTH;
  localparam int MW  = (MW0 > IO_W) ? MW0 : IO_W;
  localparam int IW  = MW + 2;

  localparam logic signed [IW-1:0] DW_MAX = IW'({1'b0, {(DATA_WIDTH-1){1'b1}}});
  localparam logic signed [IW-1:0] DW_MIN = -DW_MAX - IW'(1);
  localparam logic signed [IW-1:0] IO_MAX = IW'({1'b0, {(IO_W-1){1'b1}}});
  localparam logic signed [IW-1:0] IO_MIN = -IO_MAX - IW'(1);

  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(input logic signed [IW-1:0] x);
    logic signed [IW-1:0] y;
    y = x;
    if (x > DW_MAX) y = DW_MAX;
    else if (x < DW_MIN) y = DW_MIN;
    return DATA_WIDTH'(y);
  endfunction

  function automatic logic signed [IO_W-1:0] sat_io(input logic signed [DATA_WIDTH-1:0] v);
    logic signed [IW-1:0] y;
    y = IW'(v);
    if (y > IO_MAX) y = IO_MAX;
    else if (y < IO_MIN) y = IO_MIN;
    return IO_W'(y);
  endfunction

  function automatic logic signed [DATA_WIDTH-1:0] sat_in(input logic signed [IO_W-1:0] v);
    return sat_dw(IW'(v));
  endfunction

  // Configuration and loop state.
  logic signed [DATA_WIDTH-1:0] bd_q, g1_q, g2_q, l0_q, l1_q, l2_q;
  logic signed [DATA_WIDTH-1:0] p_q, v_q, a_q, q1_q, q2_q;
  // Per-transaction working registers.
  logic signed [DATA_WIDTH-1:0] tgt_q, e_q, d_q, na_q, nq1_q, nq2_q;
  logic signed [IW-1:0]         sum_q;
  logic signed [IO_W-1:0]       drive_q, pos_q, vel_q, acc_q;
  logic                         out_valid_q, out_valid_d;

  state_e state_q, state_d;
  op_e    op_q, op_d, op_sel;

  logic                         mul_start, mul_done;
  logic signed [DATA_WIDTH-1:0] mul_a, mul_b;
  logic signed [RW-1:0]         mul_res;

  logic                         in_acc, fold, commit;
  logic signed [IW-1:0]         rp, sum_fold;
  logic signed [DATA_WIDTH-1:0] fold_sat, pn, vn;

  rmg_mul #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    op_sel    = OP_L1Q1;
    mul_start = 1'b0;
    in_acc    = 1'b0;
    fold      = 1'b0;
    commit    = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_acc = in_valid_i;
        if (in_valid_i) state_d = S_ERR;
      end
      S_ERR: begin
        mul_start = 1'b1;
        op_sel    = OP_L1Q1;
        op_d      = OP_L1Q1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        if (mul_done) begin
          fold = 1'b1;
          case (op_q)
            OP_L1Q1: op_sel = OP_L2Q2;
            OP_L2Q2: op_sel = OP_L0E;
            OP_L0E:  op_sel = OP_ABD;
            OP_ABD:  op_sel = OP_DBD;
            OP_DBD:  op_sel = OP_Q1G1;
            OP_Q1G1: op_sel = OP_Q1G2;
            default: op_sel = OP_L1Q1;
          endcase
          if (op_q == OP_Q1G2) begin
            state_d = S_POS;
          end else begin
            mul_start = 1'b1;
            op_d      = op_sel;
          end
        end
      end
      S_POS: begin
        if (!(out_valid_q && out_stall_i)) begin
          commit  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Operand selection for the product being issued.
  always_comb begin
    case (op_sel)
      OP_L1Q1: begin mul_a = l1_q; mul_b = q1_q; end
      OP_L2Q2: begin mul_a = l2_q; mul_b = q2_q; end
      OP_L0E:  begin mul_a = l0_q; mul_b = e_q;  end
      OP_ABD:  begin mul_a = a_q;  mul_b = bd_q; end
      OP_DBD:  begin mul_a = d_q;  mul_b = bd_q; end
      OP_Q1G1: begin mul_a = q1_q; mul_b = g1_q; end
      OP_Q1G2: begin mul_a = q1_q; mul_b = g2_q; end
      default: begin mul_a = '0;   mul_b = '0;   end
    endcase
  end

  // Fold the finished rounded product into its running sum; also form the next position and velocity.
  always_comb begin
    rp = IW'(mul_res);
    case (op_q)
      OP_L1Q1: sum_fold = rp;
      OP_L2Q2, OP_L0E, OP_DBD: sum_fold = sum_q + rp;
      OP_ABD:  sum_fold = IW'(a_q) - rp;
      OP_Q1G1: sum_fold = IW'(q1_q) + IW'(q2_q) - rp;
      OP_Q1G2: sum_fold = IW'(q2_q) + IW'(e_q) - rp;
      default: sum_fold = rp;
    endcase
    fold_sat = sat_dw(sum_fold);
    pn       = sat_dw(IW'(p_q) + IW'(v_q));
    vn       = sat_dw(IW'(v_q) + IW'(a_q));
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_L1Q1;
      out_valid_q <= 1'b0;
      bd_q <= '0; g1_q <= '0; g2_q <= '0;
      l0_q <= '0; l1_q <= '0; l2_q <= '0;
      p_q  <= '0; v_q  <= '0; a_q  <= '0; q1_q <= '0; q2_q <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LAG_BW:   bd_q <= sat_in(cfg_wdata_i);
          REG_FILT_G1:  g1_q <= sat_in(cfg_wdata_i);
          REG_FILT_G2:  g2_q <= sat_in(cfg_wdata_i);
          REG_ERR_GAIN: l0_q <= sat_in(cfg_wdata_i);
          REG_ST_G1:    l1_q <= sat_in(cfg_wdata_i);
          REG_ST_G2:    l2_q <= sat_in(cfg_wdata_i);
          default: ;
        endcase
      end
      if (commit) begin
        p_q  <= pn;
        v_q  <= vn;
        a_q  <= na_q;
        q1_q <= nq1_q;
        q2_q <= nq2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) tgt_q <= sat_in(target_i);
    if (state_q == S_ERR) e_q <= sat_dw(IW'(tgt_q) - IW'(p_q));
    if (fold) begin
      sum_q <= sum_fold;
      case (op_q)
        OP_L0E:  d_q   <= fold_sat;
        OP_DBD:  na_q  <= fold_sat;
        OP_Q1G1: nq1_q <= fold_sat;
        OP_Q1G2: nq2_q <= fold_sat;
        default: ;
      endcase
    end
    if (commit) begin
      drive_q <= sat_io(d_q);
      pos_q   <= sat_io(pn);
      vel_q   <= sat_io(vn);
      acc_q   <= sat_io(na_q);
    end
  end

  assign in_stall_o         = (state_q != S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign drive_o            = drive_q;
  assign ref_position_o     = pos_q;
  assign ref_velocity_o     = vel_q;
  assign ref_acceleration_o = acc_q;

  a_done_in_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> state_q == S_MUL)
    else $error("product finished outside the multiply phase");

  a_accept_to_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_ERR)
    else $error("accepted transaction did not start the error step");

  a_result_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_POS)
    else $error("result raised without a commit");

  a_commit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POS && !(out_valid_q && out_stall_i)) |=>
      (out_valid_o && state_q == S_IDLE))
    else $error("commit did not present a result");

endmodule

@@ dv/rmg_model_monitor.sv @@
// rmg_model_monitor: watches the config, target and result channels of the reference model
// generator, runs its own Q16.16 model and compares every result. Depends on rmg_pkg.
`timescale 1ns / 1ps

module rmg_model_monitor import rmg_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [REG_IDX_W-1:0]   cfg_index_i,
  input  logic signed [IO_W-1:0] cfg_wdata_i,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic signed [IO_W-1:0] target_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [IO_W-1:0] drive_i,
  input  logic signed [IO_W-1:0] ref_position_i,
  input  logic signed [IO_W-1:0] ref_velocity_i,
  input  logic signed [IO_W-1:0] ref_acceleration_i,
  output int                     mismatch_count_o,
  output int                     pending_o,
  output int                     results_seen_o
);

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam longint WORD_MAX    = 64'sd2147483647;
  localparam longint WORD_MIN    = -64'sd2147483648;
  localparam int     PRINT_LIMIT = 40;

  typedef struct packed {
    logic signed [IO_W-1:0] drive;
    logic signed [IO_W-1:0] position;
    logic signed [IO_W-1:0] velocity;
    logic signed [IO_W-1:0] acceleration;
  } tick_result_t;

  tick_result_t expected_ticks [$];

  // model state and gains, kept wide so sums are exact before clamping
  longint pos_q, vel_q, acc_q, filt1_q, filt2_q;
  longint lag_bw, filt_g1, filt_g2, err_gain, st_gain1, st_gain2;

  int mismatches = 0;
  int pending    = 0;
  int results    = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = pending;
  assign results_seen_o   = results;

  function automatic longint clamp_word(input longint x);
    if (x > WORD_MAX) return WORD_MAX;
    if (x < WORD_MIN) return WORD_MIN;
    return x;
  endfunction

  // full product, round half up, rescale
  function automatic longint scaled_product(input longint x, input longint y);
    longint p;
    p = x * y + (64'sd1 <<< (FRAC - 1));
    return p >>> FRAC;
  endfunction

  function automatic tick_result_t advance_model(input logic signed [IO_W-1:0] tgt);
    longint err, drv;
    longint nxt_pos, nxt_vel, nxt_acc, nxt_f1, nxt_f2;
    tick_result_t res;
    err = clamp_word(longint'(tgt) - pos_q);
    drv = clamp_word(scaled_product(st_gain1, filt1_q) + scaled_product(st_gain2, filt2_q)
                     + scaled_product(err_gain, err));
    nxt_pos = clamp_word(pos_q + vel_q);
    nxt_vel = clamp_word(vel_q + acc_q);
    nxt_acc = clamp_word(acc_q - scaled_product(acc_q, lag_bw) + scaled_product(drv, lag_bw));
    nxt_f1  = clamp_word(filt1_q - scaled_product(filt1_q, filt_g1) + filt2_q);
    nxt_f2  = clamp_word(filt2_q - scaled_product(filt1_q, filt_g2) + err);
    pos_q   = nxt_pos;
    vel_q   = nxt_vel;
    acc_q   = nxt_acc;
    filt1_q = nxt_f1;
    filt2_q = nxt_f2;
    res.drive        = drv[IO_W-1:0];
    res.position     = nxt_pos[IO_W-1:0];
    res.velocity     = nxt_vel[IO_W-1:0];
    res.acceleration = nxt_acc[IO_W-1:0];
    return res;
  endfunction

  task automatic log_mismatch(input string what);
    if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t got, want;
    if (!rst_ni) begin
      {pos_q, vel_q, acc_q, filt1_q, filt2_q} = '0;
      {lag_bw, filt_g1, filt_g2, err_gain, st_gain1, st_gain2} = '0;
      expected_ticks.delete();
      pending = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_LAG_BW:   lag_bw   = longint'(cfg_wdata_i);
          REG_FILT_G1:  filt_g1  = longint'(cfg_wdata_i);
          REG_FILT_G2:  filt_g2  = longint'(cfg_wdata_i);
          REG_ERR_GAIN: err_gain = longint'(cfg_wdata_i);
          REG_ST_G1:    st_gain1 = longint'(cfg_wdata_i);
          REG_ST_G2:    st_gain2 = longint'(cfg_wdata_i);
          default: ;  // spare index, ignored by the block
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_ticks.push_back(advance_model(target_i));
      if (out_valid_i && !out_stall_i) begin
        got = {drive_i, ref_position_i, ref_velocity_i, ref_acceleration_i};
        if (expected_ticks.size() == 0) begin
          log_mismatch($sformatf("result %0d arrived with nothing expected", results));
        end else begin
          want = expected_ticks.pop_front();
          if (got.drive !== want.drive)
            log_mismatch($sformatf("result %0d drive %h, want %h",
                                   results, got.drive, want.drive));
          if (got.position !== want.position)
            log_mismatch($sformatf("result %0d position %h, want %h",
                                   results, got.position, want.position));
          if (got.velocity !== want.velocity)
            log_mismatch($sformatf("result %0d velocity %h, want %h",
                                   results, got.velocity, want.velocity));
          if (got.acceleration !== want.acceleration)
            log_mismatch($sformatf("result %0d acceleration %h, want %h",
                                   results, got.acceleration, want.acceleration));
        end
        results++;
      end
      pending = expected_ticks.size();
    end
  end

endmodule

@@ dv/reference_model_generator_tb.sv @@
// reference_model_generator_tb: drives targets and gain settings into the reference model
// generator and gives the verdict. Depends on rmg_pkg, the block and rmg_model_monitor.
`timescale 1ns / 1ps

module reference_model_generator_tb import rmg_pkg::*;;

  localparam int CLK_HALF_NS    = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 32;   // a bit over one transaction of the block
  localparam int LONG_HOLD      = 300;
  localparam int SEGMENTS       = 12;
  localparam int SEGMENT_ITEMS  = 132;

  localparam logic [IO_W-1:0] WORD_MAX  = 32'h7fff_ffff;
  localparam logic [IO_W-1:0] WORD_MIN  = 32'h8000_0000;
  localparam logic [IO_W-1:0] ONE       = 32'h0001_0000;
  localparam logic [IO_W-1:0] MINUS_ONE = 32'hffff_0000;
  localparam logic [IO_W-1:0] HALF      = 32'h0000_8000;
  localparam logic [IO_W-1:0] QUARTER   = 32'h0000_4000;

  // indexes past the register file
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef enum int {
    GAIN_MILD,
    GAIN_RANDOM,
    GAIN_EXTREME,
    GAIN_TOP,
    GAIN_BOTTOM
  } gain_style_e;

  gain_style_e plan [SEGMENTS] = '{GAIN_MILD, GAIN_RANDOM, GAIN_MILD, GAIN_EXTREME,
                                   GAIN_MILD, GAIN_TOP, GAIN_MILD, GAIN_BOTTOM,
                                   GAIN_MILD, GAIN_RANDOM, GAIN_MILD, GAIN_EXTREME};

  logic [IO_W-1:0] corner_targets [8] = '{32'h0000_0001, 32'hffff_ffff, ONE, MINUS_ONE,
                                          WORD_MAX, WORD_MIN, '0, HALF};

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [IO_W-1:0]        cfg_wdata = '0;
  logic                   in_valid  = 1'b0;
  logic signed [IO_W-1:0] target    = '0;
  logic                   out_stall = 1'b0;
  logic                   in_stall;
  logic                   out_valid;
  logic signed [IO_W-1:0] drive, position, velocity, acceleration;

  int mismatches, pending, results;
  int send_idle_pct  = 12;
  int recv_idle_pct  = 62;
  bit hold_request   = 1'b0;
  int hold_left      = 0;
  int idle_cycles    = 0;
  int settings_count = 0;

  always #(CLK_HALF_NS) clk = ~clk;

  reference_model_generator dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .target_i           (target),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .drive_o            (drive),
    .ref_position_o     (position),
    .ref_velocity_o     (velocity),
    .ref_acceleration_o (acceleration)
  );

  rmg_model_monitor monitor (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_we_i           (cfg_we),
    .cfg_index_i        (cfg_index),
    .cfg_wdata_i        (cfg_wdata),
    .in_valid_i         (in_valid),
    .in_stall_i         (in_stall),
    .target_i           (target),
    .out_valid_i        (out_valid),
    .out_stall_i        (out_stall),
    .drive_i            (drive),
    .ref_position_i     (position),
    .ref_velocity_i     (velocity),
    .ref_acceleration_i (acceleration),
    .mismatch_count_o   (mismatches),
    .pending_o          (pending),
    .results_seen_o     (results)
  );

  // result side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_request && hold_left == 0) begin
      hold_request = 1'b0;
      hold_left    = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles without a transaction, %0d results pending",
               idle_cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic logic [IO_W-1:0] pick_gain(input gain_style_e style);
    case (style)
      GAIN_MILD:   return $urandom_range(32'h0001_8000) - HALF;  // -0.5 .. 1.0
      GAIN_RANDOM: return $urandom;
      GAIN_TOP:    return WORD_MAX;
      GAIN_BOTTOM: return WORD_MIN;
      default: begin
        case ($urandom_range(5))
          0:       return WORD_MAX;
          1:       return WORD_MIN;
          2:       return '0;
          3:       return ONE;
          4:       return MINUS_ONE;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // mostly within +-16.0, some full-range words and corners
  function automatic logic [IO_W-1:0] pick_target();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(32'h0020_0000) - 32'h0010_0000;
    if (r < 85) return $urandom;
    if (r < 95) return $urandom_range(512) - 256;
    case ($urandom_range(3))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  task automatic send_target(input logic [IO_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    target   <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [IO_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic program_gains(input logic [IO_W-1:0] bd, g1, g2, l0, l1, l2);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_LAG_BW, bd);
    write_reg(REG_FILT_G1, g1);
    write_reg(REG_FILT_G2, g2);
    write_reg(REG_SPARE_B, $urandom);
    write_reg(REG_ERR_GAIN, l0);
    write_reg(REG_ST_G1, l1);
    write_reg(REG_ST_G2, l2);
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  // wait until every expected result is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero gains out of reset: everything must stay at zero
    send_target(WORD_MAX);
    send_target(WORD_MIN);
    send_target('0);
    drain();

    // unity lag and full error gain drive every state into both limits
    program_gains(ONE, HALF, QUARTER, WORD_MAX, ONE, ONE);
    repeat (6) send_target(WORD_MAX);
    repeat (6) send_target(WORD_MIN);
    foreach (corner_targets[i]) send_target(corner_targets[i]);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      if (seg == SEGMENTS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 12;
      end
      if (seg == 2 * SEGMENTS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_gains(pick_gain(plan[seg]), pick_gain(plan[seg]), pick_gain(plan[seg]),
                    pick_gain(plan[seg]), pick_gain(plan[seg]), pick_gain(plan[seg]));
      if (seg == 1 || seg == SEGMENTS - 3) hold_request = 1'b1;
      for (int n = 0; n < SEGMENT_ITEMS; n++) send_target(pick_target());
    end
    drain();

    $display("summary: %0d model updates checked over %0d gain settings", results,
             settings_count);
    $display("summary: saturation corners, spare writes, long output holds, three idle mixes");
    if (mismatches == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
